// File: sv/dics_pkg.sv
// Package with the shared types, codes and constants of the disk image index slot checker.
package dics_pkg;

  localparam int MAX_CLUSTERS_DEF = 65536;
  localparam int MAP_W = 32;
  localparam int SEC_W = 48;
  localparam int SLOT_W = 32;
  localparam int HDR_W = 17;
  localparam int SHIFT_W = 4;
  localparam int CODE_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_SECTORS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BYTES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SHIFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FORMAT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_ONLY       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_HARD_FIX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DETAILED_CHECK  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_CLUSTERS = 3'd7;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [CODE_W-1:0] FIND_NONE      = 3'd0;
  localparam logic [CODE_W-1:0] FIND_BEYOND    = 3'd1;
  localparam logic [CODE_W-1:0] FIND_MISALIGN  = 3'd2;
  localparam logic [CODE_W-1:0] FIND_PAST_END  = 3'd3;
  localparam logic [CODE_W-1:0] FIND_DUPLICATE = 3'd4;

  localparam logic [CODE_W-1:0] ACT_NONE       = 3'd0;
  localparam logic [CODE_W-1:0] ACT_ZERO       = 3'd1;
  localparam logic [CODE_W-1:0] ACT_SKIP       = 3'd2;
  localparam logic [CODE_W-1:0] ACT_SKIP_FATAL = 3'd3;
  localparam logic [CODE_W-1:0] ACT_IGNORE     = 3'd4;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic [SEC_W-1:0]   device_sectors;
    logic [SEC_W-1:0]   image_bytes;
    logic [SHIFT_W-1:0] cluster_shift;
    logic               first_format;
    logic               read_only;
    logic               allow_hard_fix;
    logic               detailed_check;
    logic [HDR_W-1:0]   header_clusters;
  } cfg_t;

  typedef struct packed {
    logic              opcode;
    logic [SLOT_W-1:0] slot_index;
    logic [SEC_W-1:0]  data_sector;
  } in_beat_t;

  typedef struct packed {
    logic [CODE_W-1:0] finding;
    logic [CODE_W-1:0] action;
    logic [SLOT_W-1:0] zero_slot;
    logic              image_clean;
    logic              fatal_seen;
    logic [31:0]       highest_block;
  } out_beat_t;

endpackage

// File: sv/dics_stream_if.sv
// Valid/ready stream interface that carries one beat of a payload type.
interface dics_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/disk_image_index_slot_checker.sv
// Top level of the disk image index slot checker.
//
//   Channel  Direction  Handshake       Beat
//   in_bus   sink       valid/ready     opcode, slot_index, data_sector
//   out_bus  source     valid/ready     finding, action, zero_slot, flags, highest_block
//   cfg_*    sink       write enable    register index and 48-bit data
//
// A check entry is accepted with the bitmap word read, then checked and written back in S_LOOK.
// A start beat runs the one-word-per-cycle sweep over the bitmap, then replies from S_REPLY.
// After reset the same sweep runs over every bitmap word before in_bus is ready.
// A result waits in the output register; a following entry stalls in its check cycle until
// the waiting beat is taken.
module disk_image_index_slot_checker import dics_pkg::*; #(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dics_stream_if.sink           in_bus,
  dics_stream_if.source         out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int MAP_WORDS = (MAX_CLUSTERS + 31) / 32;
  localparam int AW = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;

  cfg_t             cfg;
  logic             map_we;
  logic [AW-1:0]    map_waddr;
  logic [MAP_W-1:0] map_wdata;
  logic             map_re;
  logic [AW-1:0]    map_raddr;
  logic [MAP_W-1:0] map_rdata;

  dics_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dics_ram #(
    .WIDTH (MAP_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  dics_ctrl #(
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .map_we    (map_we),
    .map_waddr (map_waddr),
    .map_wdata (map_wdata),
    .map_re    (map_re),
    .map_raddr (map_raddr),
    .map_rdata (map_rdata)
  );
endmodule

// File: sv/dics_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module dics_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// File: sv/dics_cfg_regs.sv
// Configuration register file of the disk image index slot checker.
module dics_cfg_regs import dics_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);
  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_SECTORS:  cfg_nxt.device_sectors  = cfg_data[SEC_W-1:0];
        CFG_IMAGE_BYTES:     cfg_nxt.image_bytes     = cfg_data[SEC_W-1:0];
        CFG_CLUSTER_SHIFT:   cfg_nxt.cluster_shift   = cfg_data[SHIFT_W-1:0];
        CFG_FIRST_FORMAT:    cfg_nxt.first_format    = cfg_data[0];
        CFG_READ_ONLY:       cfg_nxt.read_only       = cfg_data[0];
        CFG_ALLOW_HARD_FIX:  cfg_nxt.allow_hard_fix  = cfg_data[0];
        CFG_DETAILED_CHECK:  cfg_nxt.detailed_check  = cfg_data[0];
        CFG_HEADER_CLUSTERS: cfg_nxt.header_clusters = cfg_data[HDR_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_sectors  <= '0;
      cfg_r.image_bytes     <= '0;
      cfg_r.cluster_shift   <= SHIFT_W'(11);
      cfg_r.first_format    <= 1'b0;
      cfg_r.read_only       <= 1'b1;
      cfg_r.allow_hard_fix  <= 1'b0;
      cfg_r.detailed_check  <= 1'b0;
      cfg_r.header_clusters <= HDR_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

// File: sv/dics_ctrl.sv
// Sequencer and check datapath: bitmap sweep, lookup, read-modify-write and result register.
module dics_ctrl import dics_pkg::*; #(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  dics_stream_if.sink   in_bus,
  dics_stream_if.source out_bus,
  output logic         map_we,
  output logic [((MAX_CLUSTERS + 31) / 32 > 1 ? $clog2((MAX_CLUSTERS + 31) / 32) : 1)-1:0]
                       map_waddr,
  output logic [MAP_W-1:0] map_wdata,
  output logic         map_re,
  output logic [((MAX_CLUSTERS + 31) / 32 > 1 ? $clog2((MAX_CLUSTERS + 31) / 32) : 1)-1:0]
                       map_raddr,
  input  logic [MAP_W-1:0] map_rdata
);
  localparam int MAP_WORDS = (MAX_CLUSTERS + 31) / 32;
  localparam int AW = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
  localparam int CLW = $clog2(MAX_CLUSTERS);
  localparam int BW = (AW + 5 > HDR_W + 1) ? AW + 5 : HDR_W + 1;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [HDR_W-1:0]   sweep_hc_r, sweep_hc_nxt;
  logic               start_pend_r, start_pend_nxt;
  logic [31:0]        top_r, top_nxt;
  logic               clean_r, clean_nxt;
  logic               fatal_r, fatal_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_r, out_nxt;

  logic [SLOT_W-1:0]  slot_r;
  logic [SEC_W-1:0]   sec_r;
  logic [CLW-1:0]     blk_r;
  logic               blk_over_r;

  logic               accept;
  logic               out_free;
  logic [SEC_W-1:0]   blk_in;
  logic [HDR_W-1:0]   hc_eff;
  logic [BW-1:0]      base;
  logic [BW-1:0]      hc_w;
  logic [BW-1:0]      diff;
  logic [MAP_W-1:0]   preset;
  logic               dev_hit, mis_hit, end_hit, dup_hit, passed;
  logic               hard, skip;
  logic [CODE_W-1:0]  finding, action;
  logic [63:0]        end_pos;

  assign accept = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE);
  assign out_bus.valid = out_valid_r;
  assign out_bus.data = out_r;

  assign blk_in = in_bus.data.data_sector >> cfg.cluster_shift;
  assign map_re = accept;
  assign map_raddr = AW'(blk_in >> 5);
  assign hc_eff = (cfg.header_clusters == '0) ? HDR_W'(1) : cfg.header_clusters;

  always_comb begin
    base = BW'(cnt_r) << 5;
    hc_w = BW'(sweep_hc_r);
    diff = hc_w - base;
    if (hc_w <= base) begin
      preset = '0;
    end else if (diff >= BW'(MAP_W)) begin
      preset = '1;
    end else begin
      preset = ~({MAP_W{1'b1}} << diff[4:0]);
    end
  end

  always_comb begin
    end_pos = (64'(blk_r) + 64'd1) << (6'd9 + 6'(cfg.cluster_shift));
    dev_hit = (SEC_W'(slot_r) << cfg.cluster_shift) > cfg.device_sectors;
    mis_hit = cfg.first_format && ((sec_r & ~({SEC_W{1'b1}} << cfg.cluster_shift)) != '0);
    end_hit = blk_over_r || (end_pos > 64'(cfg.image_bytes));
    dup_hit = cfg.detailed_check && map_rdata[blk_r[4:0]];
    passed = !dev_hit && !mis_hit && !end_hit;
    if (dev_hit) begin
      finding = FIND_BEYOND;
    end else if (mis_hit) begin
      finding = FIND_MISALIGN;
    end else if (end_hit) begin
      finding = FIND_PAST_END;
    end else if (dup_hit) begin
      finding = FIND_DUPLICATE;
    end else begin
      finding = FIND_NONE;
    end
    hard = (finding != FIND_NONE) && (finding != FIND_BEYOND);
    skip = cfg.read_only || (hard && !cfg.allow_hard_fix);
    if (finding == FIND_NONE) begin
      action = ACT_NONE;
    end else if (skip) begin
      action = hard ? ACT_SKIP_FATAL : ACT_SKIP;
    end else begin
      action = (finding == FIND_DUPLICATE) ? ACT_IGNORE : ACT_ZERO;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    sweep_hc_nxt = sweep_hc_r;
    start_pend_nxt = start_pend_r;
    top_nxt = top_r;
    clean_nxt = clean_r;
    fatal_nxt = fatal_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_nxt = out_r;
    map_we = 1'b0;
    map_waddr = cnt_r;
    map_wdata = preset;
    case (state_r)
      S_CLEAR: begin
        map_we = 1'b1;
        if (cnt_r == AW'(MAP_WORDS - 1)) begin
          cnt_nxt = '0;
          state_nxt = start_pend_r ? S_REPLY : S_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_bus.data.opcode == OP_START) begin
            sweep_hc_nxt = hc_eff;
            top_nxt = 32'(hc_eff - HDR_W'(1));
            clean_nxt = 1'b1;
            fatal_nxt = 1'b0;
            start_pend_nxt = 1'b1;
            state_nxt = S_CLEAR;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (out_free) begin
          if (passed && cfg.detailed_check) begin
            map_we = 1'b1;
            map_waddr = AW'(blk_r >> 5);
            map_wdata = map_rdata | (MAP_W'(1) << blk_r[4:0]);
          end
          if (passed && (32'(blk_r) > top_r)) begin
            top_nxt = 32'(blk_r);
          end
          if (finding != FIND_NONE && skip) begin
            clean_nxt = 1'b0;
            if (hard) begin
              fatal_nxt = 1'b1;
            end
          end
          out_nxt.finding = finding;
          out_nxt.action = action;
          out_nxt.zero_slot = (action == ACT_ZERO) ? slot_r : '0;
          out_nxt.image_clean = clean_nxt;
          out_nxt.fatal_seen = fatal_nxt;
          out_nxt.highest_block = top_nxt;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_nxt.finding = FIND_NONE;
          out_nxt.action = ACT_NONE;
          out_nxt.zero_slot = '0;
          out_nxt.image_clean = clean_r;
          out_nxt.fatal_seen = fatal_r;
          out_nxt.highest_block = top_r;
          out_valid_nxt = 1'b1;
          start_pend_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r <= '0;
      sweep_hc_r <= HDR_W'(1);
      start_pend_r <= 1'b0;
      top_r <= '0;
      clean_r <= 1'b1;
      fatal_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      sweep_hc_r <= sweep_hc_nxt;
      start_pend_r <= start_pend_nxt;
      top_r <= top_nxt;
      clean_r <= clean_nxt;
      fatal_r <= fatal_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      slot_r <= in_bus.data.slot_index;
      sec_r <= in_bus.data.data_sector;
      blk_r <= CLW'(blk_in);
      blk_over_r <= blk_in >= SEC_W'(MAX_CLUSTERS);
    end
  end
endmodule
